// ===== rtl/b64lf_pkg.sv =====
// Shared types, constants and helper functions for the base64 line framer.
`default_nettype none

package b64lf_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = 2;
    localparam int unsigned StepNum = 7;

    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    localparam logic [7:0] ChV     = 8'h56;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPad   = 8'h3D;
    localparam logic [7:0] ChNl    = 8'h0A;

    // Character positions within the work of one input item.
    localparam logic [2:0] StepV     = 3'd0;
    localparam logic [2:0] StepSpace = 3'd1;
    localparam logic [2:0] StepSym0  = 3'd2;
    localparam logic [2:0] StepSym1  = 3'd3;
    localparam logic [2:0] StepSym2  = 3'd4;
    localparam logic [2:0] StepSym3  = 3'd5;
    localparam logic [2:0] StepNl    = 3'd6;

    // One unit of output work: what a single input item makes the back end emit.
    typedef struct packed {
        logic        hdr;
        logic [1:0]  grp_n;
        logic [23:0] grp;
        logic        nl;
        logic        fin;
        logic [31:0] crc;
    } t_job;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'd0, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'd0, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'd0, v - 6'd52};
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64lf_front.sv =====
// Front end: accepts payload bytes, tracks line and group state and the CRC, issues jobs.
`default_nettype none

module b64lf_front #(
    parameter int unsigned BYTES_PER_LINE = 36
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_byte,
    input  wire              i_fin,
    output logic             o_ready,
    input  wire              i_full,
    output logic             o_push,
    output b64lf_pkg::t_job  o_job
);

    localparam int unsigned LW = $clog2(BYTES_PER_LINE + 1);

    logic [LW-1:0] r_fill, n_fill;
    logic [15:0]   r_pend, n_pend;
    logic [1:0]    r_phase, n_phase;
    logic [31:0]   r_crc, n_crc;

    logic          acc;
    logic [LW-1:0] fill1;
    logic          end_line;
    logic [1:0]    ph1;
    b64lf_pkg::t_job job;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_fill  = r_fill;
        n_pend  = r_pend;
        n_phase = r_phase;
        n_crc   = b64lf_pkg::crc_byte(r_crc, i_byte);
        fill1   = r_fill + LW'(1);
        end_line = i_fin || (fill1 >= LW'(BYTES_PER_LINE));
        ph1     = r_phase + 2'd1;

        job.hdr   = (r_fill == '0);
        job.grp_n = 2'd0;
        job.grp   = 24'd0;
        job.nl    = end_line;
        job.fin   = i_fin;
        job.crc   = ~n_crc;

        n_fill = fill1;
        if (r_phase == 2'd2) begin
            job.grp   = {r_pend, i_byte};
            job.grp_n = 2'd3;
            n_pend    = 16'd0;
            n_phase   = 2'd0;
        end else begin
            n_pend  = {r_pend[7:0], i_byte};
            n_phase = ph1;
            if (end_line) begin
                job.grp   = (ph1 == 2'd1) ? {i_byte, 16'd0} : {r_pend[7:0], i_byte, 8'd0};
                job.grp_n = ph1;
                n_pend    = 16'd0;
                n_phase   = 2'd0;
            end
        end

        if (end_line) begin
            n_fill = '0;
            if (i_fin) begin
                n_crc = b64lf_pkg::CrcInit;
            end
        end
    end

    assign o_job  = job;
    assign o_push = acc && (job.hdr || (job.grp_n != 2'd0) || job.nl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pend  <= 16'd0;
            r_phase <= 2'd0;
            r_crc   <= b64lf_pkg::CrcInit;
        end else if (acc) begin
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_phase <= n_phase;
            r_crc   <= n_crc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64lf_job_fifo.sv =====
// Short job queue between the front end and the character sequencer.
`default_nettype none

module b64lf_job_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  b64lf_pkg::t_job  i_job,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output b64lf_pkg::t_job  o_job
);

    b64lf_pkg::t_job r_mem [b64lf_pkg::QDepth];
    logic [b64lf_pkg::QAw-1:0] r_wp, r_rp;
    logic [b64lf_pkg::QAw:0]   r_cnt;
    logic do_pop;

    assign o_full  = (r_cnt == (b64lf_pkg::QAw+1)'(b64lf_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64lf_back.sv =====
// Back end: walks each job character by character into a registered output stage.
`default_nettype none

module b64lf_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_job_valid,
    input  b64lf_pkg::t_job  i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [7:0]       o_char,
    output logic             o_last,
    output logic             o_done,
    output logic [31:0]      o_crc
);

    localparam int unsigned SN = b64lf_pkg::StepNum;

    b64lf_pkg::t_job r_job;
    logic [SN-1:0]   r_mask, n_mask;
    logic            r_valid;
    logic [7:0]      r_char;
    logic            r_last;
    logic            r_done;
    logic [31:0]     r_crc;

    b64lf_pkg::t_job cur_job;
    logic [SN-1:0]   cur_mask;
    logic [SN-1:0]   head_mask;
    logic [2:0]      step;
    logic            adv;
    logic            use_head;
    logic [7:0]      ch;

    assign head_mask = {i_job.nl, {4{i_job.grp_n != 2'd0}}, {2{i_job.hdr}}};
    assign use_head  = (r_mask == '0);
    assign cur_job   = use_head ? i_job : r_job;
    assign cur_mask  = use_head ? (i_job_valid ? head_mask : '0) : r_mask;
    assign adv       = !r_valid || i_ready;
    assign o_pop     = adv && use_head && i_job_valid;

    always_comb begin
        step = 3'd0;
        for (int k = SN - 1; k >= 0; k--) begin
            if (cur_mask[k]) begin
                step = 3'(k);
            end
        end
        n_mask = cur_mask & ~(SN'(1) << step);
    end

    always_comb begin
        unique case (step)
            b64lf_pkg::StepV:     ch = b64lf_pkg::ChV;
            b64lf_pkg::StepSpace: ch = b64lf_pkg::ChSpace;
            b64lf_pkg::StepSym0:  ch = b64lf_pkg::b64_sym(cur_job.grp[23:18]);
            b64lf_pkg::StepSym1:  ch = b64lf_pkg::b64_sym(cur_job.grp[17:12]);
            b64lf_pkg::StepSym2:  ch = (cur_job.grp_n > 2'd1) ?
                                       b64lf_pkg::b64_sym(cur_job.grp[11:6]) : b64lf_pkg::ChPad;
            b64lf_pkg::StepSym3:  ch = (cur_job.grp_n > 2'd2) ?
                                       b64lf_pkg::b64_sym(cur_job.grp[5:0]) : b64lf_pkg::ChPad;
            b64lf_pkg::StepNl:    ch = b64lf_pkg::ChNl;
            default:              ch = b64lf_pkg::ChNl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mask  <= '0;
        end else if (adv) begin
            r_valid <= (cur_mask != '0);
            r_mask  <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_job  <= cur_job;
            r_char <= ch;
            r_last <= (n_mask == '0);
            r_done <= (step == b64lf_pkg::StepNl) && cur_job.fin;
            r_crc  <= ((step == b64lf_pkg::StepNl) && cur_job.fin) ? cur_job.crc : 32'd0;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_done  = r_done;
    assign o_crc   = r_crc;

endmodule

`default_nettype wire

// ===== rtl/base64_line_framer_crc32.sv =====
// Base64 line framer with running CRC-32: front end, job queue and character sequencer.
//
// Input stream: one payload byte per item on s_axis_tdata, s_axis_tlast marking the
// payload's final byte. Output stream: one ASCII character per item. Lines read
// "V ", base64 of up to BYTES_PER_LINE bytes, then a newline; a group cut short at
// a line end or the payload end is padded with '='. m_axis_tlast marks the last
// character caused by one input byte, m_axis_tuser marks the payload's final
// newline, and the upper tdata bits then carry the complemented CRC-32.
// The first character of a byte passes through the job queue and then the registered
// output stage before it is presented; a receiver stall can hold it in between.
// The output stage gives one character per cycle while the receiver is ready; a byte
// causes zero to seven characters, about 1.4 on average, and a byte that causes
// none is taken without entering the queue. The front end takes one byte per cycle
// while the four-entry job queue has room.
// Reset clears line position, group state and queue, and sets the CRC to all ones.
// When the receiver stalls, the output stage holds its character and the queue
// fills; s_axis_tready drops only when the queue is full.
`default_nettype none

module base64_line_framer_crc32 #(
    parameter int unsigned BYTES_PER_LINE = 36
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_char, [39:8] crc_value
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // payload_done
);

    b64lf_pkg::t_job push_job, head_job;
    logic push, full, pop, head_valid;
    logic [7:0]  out_char;
    logic [31:0] out_crc;

    b64lf_front #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_fin   (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    b64lf_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    b64lf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (out_char),
        .o_last      (m_axis_tlast),
        .o_done      (m_axis_tuser),
        .o_crc       (out_crc)
    );

    assign m_axis_tdata = {out_crc, out_char};

endmodule

`default_nettype wire
